### rtl/core/lcd4_pkg.sv
// Shared constants, types and lookup functions for the 4-bit character LCD interface.
package lcd4_pkg;

    // Command codes
    localparam logic [2:0] CMD_INIT   = 3'd0;
    localparam logic [2:0] CMD_CLEAR  = 3'd1;
    localparam logic [2:0] CMD_GOTO   = 3'd2;
    localparam logic [2:0] CMD_CHAR   = 3'd3;
    localparam logic [2:0] CMD_NUMBER = 3'd4;

    // LCD command bytes and row bases
    localparam logic [7:0] ROW0_BASE    = 8'h80;
    localparam logic [7:0] ROW1_BASE    = 8'hC0;
    localparam logic [7:0] LCD_RESET    = 8'h30;
    localparam logic [7:0] LCD_4BIT     = 8'h20;
    localparam logic [7:0] LCD_FUNC_SET = 8'h28;
    localparam logic [7:0] LCD_DISP_ON  = 8'h0C;
    localparam logic [7:0] LCD_ENTRY    = 8'h06;
    localparam logic [7:0] LCD_CLS      = 8'h01;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;

    // Hold times in microseconds
    localparam logic [15:0] EN_HIGH_US    = 16'd1;
    localparam logic [15:0] EN_LOW_US     = 16'd50;
    localparam logic [15:0] POWER_UP_US   = 16'd50000;
    localparam logic [15:0] EXTRA_NONE    = 16'd0;
    localparam logic [15:0] EXTRA_BYTE    = 16'd50;
    localparam logic [15:0] EXTRA_CLEAR   = 16'd2050;
    localparam logic [15:0] EXTRA_RESET1  = 16'd5000;
    localparam logic [15:0] EXTRA_RESET2  = 16'd150;

    // Init sequence: eight groups, the first four single nibbles
    localparam logic [2:0] INIT_LAST_STEP = 3'd7;
    // Decimal places: ten thousands down to units
    localparam logic [2:0] UNITS_PLACE    = 3'd4;

    typedef struct packed {
        logic [7:0]  data;
        logic        single;
        logic [15:0] extra;
    } group_t;

    function automatic group_t init_step(input logic [2:0] idx);
        group_t g;
        g.single = 1'b0;
        g.extra  = EXTRA_BYTE;
        g.data   = LCD_CLS;
        case (idx)
            3'd0:
            begin
                g.data   = LCD_RESET;
                g.single = 1'b1;
                g.extra  = EXTRA_RESET1;
            end
            3'd1:
            begin
                g.data   = LCD_RESET;
                g.single = 1'b1;
                g.extra  = EXTRA_RESET2;
            end
            3'd2:
            begin
                g.data   = LCD_RESET;
                g.single = 1'b1;
                g.extra  = EXTRA_NONE;
            end
            3'd3:
            begin
                g.data   = LCD_4BIT;
                g.single = 1'b1;
                g.extra  = EXTRA_NONE;
            end
            3'd4: g.data = LCD_FUNC_SET;
            3'd5: g.data = LCD_DISP_ON;
            3'd6: g.data = LCD_ENTRY;
            default:
            begin
                g.data  = LCD_CLS;
                g.extra = EXTRA_CLEAR;
            end
        endcase
        return g;
    endfunction

    function automatic logic [15:0] pow10(input logic [2:0] place);
        logic [15:0] p;
        case (place)
            3'd0:    p = 16'd10000;
            3'd1:    p = 16'd1000;
            3'd2:    p = 16'd100;
            3'd3:    p = 16'd10;
            default: p = 16'd1;
        endcase
        return p;
    endfunction

endpackage

### rtl/core/char_lcd_nibble_interface_core.sv
// Top level of the 4-bit character LCD interface: command sequencer and pin-state emitter.
//
// Usage: drive cmd, value, row and col and raise start; the command is taken at a
// rising edge where start is high and busy is low. The block then raises busy and
// emits a run of pin states, one per strobe cycle: rs_pin, en_pin, data_nibble,
// hold_us (microseconds to keep that state) and last on the final state.
// Each state is shown for exactly one cycle; the receiver cannot stall it and
// must capture it when strobe is high. Unknown commands (5 to 7) are dropped and
// busy stays low, so the next command may be taken at the following edge.
// Initialize, clear, goto and write character emit one state per cycle (25, 4, 4 and
// 4 states). Write number runs one shared compare-and-subtract unit over the five
// decimal places, from ten thousands down to units, subtracting the power of ten
// while it fits; after each place it emits 4 states for the digit, but drops
// leading zeros (the units digit is always printed). busy drops in the cycle that
// shows the last state, so a new command may be taken then. Reset clears the
// sequencer and the strobe; no state is emitted.
module char_lcd_nibble_interface_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [15:0] value,
    input  logic        row,
    input  logic [5:0]  col,
    output logic        strobe,
    output logic        rs_pin,
    output logic        en_pin,
    output logic [3:0]  data_nibble,
    output logic [15:0] hold_us,
    output logic        last
);
    import lcd4_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_POWER, S_SEND, S_DIGIT} state_t;
    typedef enum logic [1:0] {M_SINGLE, M_INIT, M_NUMBER} mode_t;

    state_t      state_reg;
    mode_t       mode_reg;
    logic [7:0]  byte_reg;
    logic        rs_reg;
    logic        single_reg;
    logic [15:0] extra_reg;
    logic [1:0]  phase_reg;
    logic [2:0]  init_idx_reg;
    logic [2:0]  place_reg;
    logic [15:0] rem_reg;
    logic [3:0]  digit_reg;
    logic        started_reg;

    logic        strobe_reg;
    logic        rs_out_reg;
    logic        en_out_reg;
    logic [3:0]  nib_out_reg;
    logic [15:0] hold_out_reg;
    logic        last_out_reg;

    logic        final_phase;
    logic        group_last;
    logic [15:0] place_value;
    logic        can_sub;
    logic        emit_digit;
    logic [7:0]  goto_byte;
    group_t      next_init;
    group_t      first_init;

    // Decode the emitter position and the shared subtract unit
    always_comb
    begin
        final_phase = single_reg ? (phase_reg == 2'd1) : (phase_reg == 2'd3);
        group_last  = (mode_reg == M_SINGLE)
                   || ((mode_reg == M_INIT) && (init_idx_reg == INIT_LAST_STEP))
                   || ((mode_reg == M_NUMBER) && (place_reg == UNITS_PLACE));
        place_value = pow10(place_reg);
        can_sub     = (rem_reg >= place_value);
        emit_digit  = (digit_reg != 4'd0) || started_reg || (place_reg == UNITS_PLACE);
        goto_byte   = (row ? ROW1_BASE : ROW0_BASE) + {2'b00, col};
        next_init   = init_step(init_idx_reg + 3'd1);
        first_init  = init_step(3'd0);
    end

    // Sequencer and registered pin-state outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            strobe_reg   <= 1'b0;
            mode_reg     <= M_SINGLE;
            byte_reg     <= 8'h00;
            rs_reg       <= 1'b0;
            single_reg   <= 1'b0;
            extra_reg    <= EXTRA_BYTE;
            phase_reg    <= 2'd0;
            init_idx_reg <= 3'd0;
            place_reg    <= 3'd0;
            rem_reg      <= 16'd0;
            digit_reg    <= 4'd0;
            started_reg  <= 1'b0;
            rs_out_reg   <= 1'b0;
            en_out_reg   <= 1'b0;
            nib_out_reg  <= 4'h0;
            hold_out_reg <= 16'd0;
            last_out_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    phase_reg <= 2'd0;
                    mode_reg  <= M_SINGLE;
                    rs_reg    <= 1'b0;
                    single_reg <= 1'b0;
                    extra_reg <= EXTRA_BYTE;
                    if (start)
                    begin
                        case (cmd)
                            CMD_INIT:
                            begin
                                init_idx_reg <= 3'd0;
                                state_reg    <= S_POWER;
                            end
                            CMD_CLEAR:
                            begin
                                byte_reg  <= LCD_CLS;
                                extra_reg <= EXTRA_CLEAR;
                                state_reg <= S_SEND;
                            end
                            CMD_GOTO:
                            begin
                                byte_reg  <= goto_byte;
                                state_reg <= S_SEND;
                            end
                            CMD_CHAR:
                            begin
                                byte_reg  <= value[7:0];
                                rs_reg    <= 1'b1;
                                state_reg <= S_SEND;
                            end
                            CMD_NUMBER:
                            begin
                                mode_reg    <= M_NUMBER;
                                rem_reg     <= value;
                                place_reg   <= 3'd0;
                                digit_reg   <= 4'd0;
                                started_reg <= 1'b0;
                                state_reg   <= S_DIGIT;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end

                S_POWER:
                begin
                    // Emit the power-up wait, then load the first init group
                    strobe_reg   <= 1'b1;
                    rs_out_reg   <= 1'b0;
                    en_out_reg   <= 1'b0;
                    nib_out_reg  <= 4'h0;
                    hold_out_reg <= POWER_UP_US;
                    last_out_reg <= 1'b0;
                    mode_reg     <= M_INIT;
                    byte_reg     <= first_init.data;
                    single_reg   <= first_init.single;
                    extra_reg    <= first_init.extra;
                    phase_reg    <= 2'd0;
                    state_reg    <= S_SEND;
                end

                S_SEND:
                begin
                    strobe_reg   <= 1'b1;
                    rs_out_reg   <= rs_reg;
                    en_out_reg   <= ~phase_reg[0];
                    nib_out_reg  <= phase_reg[1] ? byte_reg[3:0] : byte_reg[7:4];
                    hold_out_reg <= phase_reg[0]
                                  ? (final_phase ? EN_LOW_US + extra_reg : EN_LOW_US)
                                  : EN_HIGH_US;
                    last_out_reg <= final_phase && group_last;
                    phase_reg    <= phase_reg + 2'd1;
                    if (final_phase)
                    begin
                        phase_reg <= 2'd0;
                        if (group_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else if (mode_reg == M_INIT)
                        begin
                            // Advance to the next init group
                            init_idx_reg <= init_idx_reg + 3'd1;
                            byte_reg     <= next_init.data;
                            single_reg   <= next_init.single;
                            extra_reg    <= next_init.extra;
                        end
                        else
                        begin
                            // Advance to the next decimal place
                            place_reg <= place_reg + 3'd1;
                            digit_reg <= 4'd0;
                            state_reg <= S_DIGIT;
                        end
                    end
                end

                S_DIGIT:
                begin
                    if (can_sub)
                    begin
                        rem_reg   <= rem_reg - place_value;
                        digit_reg <= digit_reg + 4'd1;
                    end
                    else if (emit_digit)
                    begin
                        byte_reg    <= CHAR_ZERO + {4'h0, digit_reg};
                        rs_reg      <= 1'b1;
                        single_reg  <= 1'b0;
                        extra_reg   <= EXTRA_BYTE;
                        started_reg <= 1'b1;
                        phase_reg   <= 2'd0;
                        state_reg   <= S_SEND;
                    end
                    else
                    begin
                        // Drop a leading zero
                        place_reg <= place_reg + 3'd1;
                        digit_reg <= 4'd0;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign strobe      = strobe_reg;
    assign rs_pin      = rs_out_reg;
    assign en_pin      = en_out_reg;
    assign data_nibble = nib_out_reg;
    assign hold_us     = hold_out_reg;
    assign last        = last_out_reg;

    // The final state of a command leaves the block ready
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> !busy)
        else $error("last state shown while still busy");

    // A known command is taken up
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd <= CMD_NUMBER) |=> busy)
        else $error("accepted command did not raise busy");

    // An enable pulse is always the short hold
    a_en_hold: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && en_pin |-> hold_us == EN_HIGH_US)
        else $error("enable-high state with wrong hold");

    // Nothing is emitted without a command
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !start |=> !strobe)
        else $error("state emitted while idle");

endmodule
